@@ design/lpms_pkg.sv @@
// Shared types, codes and defaults for the light pulse Morse symbolizer.
package lpms_pkg;

   // default parameter values
   localparam int MAX_SYMBOLS_DEF = 50;
   localparam int SAMPLE_BITS_DEF = 12;

   // fixed field widths
   localparam int TIME_W   = 32;
   localparam int THRESH_W = 12;
   localparam int CFG_W    = 16;
   localparam int CNT_W    = 6;
   localparam int KIND_W   = 3;
   localparam int CSR_IDX_W = 3;

   // minimum pulse length for a dash
   localparam logic [TIME_W-1:0] DASH_MS = 32'd175;

   // event codes
   localparam logic [KIND_W-1:0] EV_DOT     = 3'd0;
   localparam logic [KIND_W-1:0] EV_DASH    = 3'd1;
   localparam logic [KIND_W-1:0] EV_SPACE   = 3'd2;
   localparam logic [KIND_W-1:0] EV_END_OK  = 3'd3;
   localparam logic [KIND_W-1:0] EV_END_BAD = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_LIGHT_THRESHOLD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_READ_INTERVAL   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DEBOUNCE        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LETTER_GAP      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MSG_TIMEOUT     = 3'd4;

   // register reset values
   localparam logic [THRESH_W-1:0] THRESH_RST   = 12'd2048;
   localparam logic [CFG_W-1:0]    INTERVAL_RST = 16'd10;
   localparam logic [CFG_W-1:0]    DEBOUNCE_RST = 16'd50;
   localparam logic [CFG_W-1:0]    GAP_RST      = 16'd500;
   localparam logic [CFG_W-1:0]    TIMEOUT_RST  = 16'd3000;

   typedef struct packed {
      logic [THRESH_W-1:0] light_threshold;
      logic [CFG_W-1:0]    read_interval_ms;
      logic [CFG_W-1:0]    debounce_ms;
      logic [CFG_W-1:0]    letter_gap_ms;
      logic [CFG_W-1:0]    message_timeout_ms;
   } cfg_type;

   // classified poll handed from front to back
   typedef struct packed {
      logic [TIME_W-1:0] now_ms;
      logic              light;
   } poll_type;

   // result item
   typedef struct packed {
      logic [KIND_W-1:0] event_kind;
      logic [CNT_W-1:0]  message_length;
   } event_type;

endpackage

@@ design/lpms_fifo.sv @@
// Small register-based FIFO used for the poll and result queues.
module lpms_fifo
   import lpms_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ design/lpms_front.sv @@
// Front part: poll rate filter and light/dark classification.
module lpms_front
   import lpms_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [TIME_W-1:0]      req_now_ms,
   input  logic [SAMPLE_BITS-1:0] req_sample_a,
   input  logic [SAMPLE_BITS-1:0] req_sample_b,
   input  logic [SAMPLE_BITS-1:0] req_sample_c,
   output logic                   poll_push,
   output poll_type               poll_data,
   input  logic                   poll_full
);

   localparam int SW = SAMPLE_BITS + 2;
   localparam int CW = (SW > THRESH_W + 2) ? SW : THRESH_W + 2;

   logic [TIME_W-1:0] last_poll_ff, last_poll_in;
   logic [TIME_W-1:0] elapsed;
   logic              take;
   logic [SW-1:0]     sum;
   logic [CW-1:0]     limit;

   assign req_full = poll_full;

   // polls closer than the read interval are dropped
   assign elapsed = req_now_ms - last_poll_ff;
   assign take    = (elapsed >= TIME_W'(cfg.read_interval_ms));

   // floor(sum/3) > thr  is the same as  sum > 3*thr + 2
   assign sum   = SW'(req_sample_a) + SW'(req_sample_b) + SW'(req_sample_c);
   assign limit = CW'(cfg.light_threshold) * CW'(3) + CW'(2);

   assign poll_push         = req_push && !poll_full && take;
   assign poll_data.now_ms  = req_now_ms;
   assign poll_data.light   = (CW'(sum) > limit);

   assign last_poll_in = poll_push ? req_now_ms : last_poll_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_poll_ff <= '0;
      end else begin
         last_poll_ff <= last_poll_in;
      end
   end

endmodule

@@ design/lpms_back.sv @@
// Back part: debounced edge handling, symbol events and message end.
module lpms_back
   import lpms_pkg::*;
#(
   parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      poll_empty,
   output logic      poll_pop,
   input  poll_type  poll_data,
   output logic      ev_push,
   output event_type ev_data,
   input  logic      ev_full
);

   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SYMBOLS + 1);
   localparam logic [CNT_W-1:0] CNT_LIM = CNT_W'(MAX_SYMBOLS);

   logic [TIME_W-1:0] last_change_ff, last_change_in;
   logic              light_on_ff, light_on_in;
   logic              receiving_ff, receiving_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              last_space_ff, last_space_in;
   logic              dbl_space_ff, dbl_space_in;

   logic [TIME_W-1:0] since;
   logic [CNT_W-1:0]  count_inc;
   logic              edge_ok;
   logic              go;

   assign go        = !poll_empty && !ev_full;
   assign poll_pop  = go;
   assign since     = poll_data.now_ms - last_change_ff;
   assign edge_ok   = (poll_data.light != light_on_ff) &&
                      (since > TIME_W'(cfg.debounce_ms));
   assign count_inc = (count_ff < CNT_MAX) ? count_ff + CNT_W'(1) : count_ff;

   // per-poll state update and event selection
   always_comb begin
      last_change_in = last_change_ff;
      light_on_in    = light_on_ff;
      receiving_in   = receiving_ff;
      count_in       = count_ff;
      last_space_in  = last_space_ff;
      dbl_space_in   = dbl_space_ff;
      ev_push        = 1'b0;
      ev_data.event_kind     = EV_DOT;
      ev_data.message_length = count_inc;
      if (go) begin
         if (edge_ok) begin
            if (light_on_ff) begin
               // end of a light pulse
               count_in      = count_inc;
               last_space_in = 1'b0;
               receiving_in  = 1'b1;
               ev_push       = 1'b1;
               ev_data.event_kind = (since >= DASH_MS) ? EV_DASH : EV_DOT;
            end else if (receiving_ff && since >= TIME_W'(cfg.letter_gap_ms)) begin
               // long dark gap: letter space
               dbl_space_in  = dbl_space_ff | last_space_ff;
               last_space_in = 1'b1;
               count_in      = count_inc;
               ev_push       = 1'b1;
               ev_data.event_kind = EV_SPACE;
            end
            last_change_in = poll_data.now_ms;
            light_on_in    = poll_data.light;
         end else if (receiving_ff && since > TIME_W'(cfg.message_timeout_ms)) begin
            // quiet too long: close the message
            if (count_ff != '0) begin
               ev_push = 1'b1;
               ev_data.event_kind = (dbl_space_ff || count_ff > CNT_LIM) ?
                                    EV_END_BAD : EV_END_OK;
               ev_data.message_length = count_ff;
            end
            count_in      = '0;
            last_space_in = 1'b0;
            dbl_space_in  = 1'b0;
            receiving_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_change_ff <= '0;
         light_on_ff    <= 1'b0;
         receiving_ff   <= 1'b0;
         count_ff       <= '0;
         last_space_ff  <= 1'b0;
         dbl_space_ff   <= 1'b0;
      end else begin
         last_change_ff <= last_change_in;
         light_on_ff    <= light_on_in;
         receiving_ff   <= receiving_in;
         count_ff       <= count_in;
         last_space_ff  <= last_space_in;
         dbl_space_ff   <= dbl_space_in;
      end
   end

   // no symbols or space history outside a message
   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      !receiving_ff |-> (count_ff == '0 && !last_space_ff && !dbl_space_ff))
      else $error("symbol state left over outside a message");

   // reported length is nonzero and stays within the saturation limit
   a_len_max: assert property (@(posedge clock) disable iff (reset)
      ev_push |-> (ev_data.message_length <= CNT_MAX && ev_data.message_length != '0))
      else $error("message length out of range");

   // message end starts a fresh message
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (ev_push && (ev_data.event_kind == EV_END_OK || ev_data.event_kind == EV_END_BAD))
      |=> (count_ff == '0 && !receiving_ff))
      else $error("message end did not clear the symbol count");

   // a double space always marks the message bad
   a_dbl_bad: assert property (@(posedge clock) disable iff (reset)
      (ev_push && dbl_space_ff && ev_data.event_kind == EV_END_OK) |-> 1'b0)
      else $error("message with double space reported valid");

endmodule

@@ design/light_pulse_morse_symbolizer.sv @@
// Top level of the light pulse Morse symbolizer: registers, queues and the two parts.
//
// Input channel (req_*): one sensor poll per item, pushed when req_full is low.
// Polls closer than read_interval_ms to the last processed poll are taken and
// dropped. Processed polls are classified light or dark and queued (4 deep) for
// the back part, which handles debounced edges and message timeout.
// Result channel (rsp_*): dot, dash, letter space or message end with the symbol
// count; the oldest result is shown while rsp_empty is low and leaves on rsp_pop.
// Throughput: one poll per cycle, set by the back part, while the result queue has room.
// A result is visible once its poll is written into the front queue and the back part
// update has pushed it into the result queue.
// When the receiver stops popping, the result queue (2 deep) fills, the back part
// holds, the front queue fills and req_full rises; no item is lost.
// Reset (synchronous): registers return to defaults, all timing and message state
// clears, both queues empty. Registers are written through csr_*; the user must
// write them only while the block is idle, not enforced; unknown indexes are ignored.
module light_pulse_morse_symbolizer
   import lpms_pkg::*;
#(
   parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [TIME_W-1:0]      req_now_ms,
   input  logic [SAMPLE_BITS-1:0] req_sample_a,
   input  logic [SAMPLE_BITS-1:0] req_sample_b,
   input  logic [SAMPLE_BITS-1:0] req_sample_c,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [KIND_W-1:0]      rsp_event_kind,
   output logic [CNT_W-1:0]       rsp_message_length,
   input  logic                   csr_write_enable,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CFG_W-1:0]       csr_write_data
);

   localparam int POLL_W = $bits(poll_type);
   localparam int EV_W   = $bits(event_type);

   cfg_type            cfg_ff, cfg_in;
   logic               poll_push, poll_full, poll_pop, poll_empty;
   poll_type           poll_wr, poll_rd;
   logic [POLL_W-1:0]  poll_rd_bits;
   logic               ev_push, ev_full;
   event_type          ev_wr, ev_rd;
   logic [EV_W-1:0]    ev_rd_bits;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_LIGHT_THRESHOLD: cfg_in.light_threshold    = csr_write_data[THRESH_W-1:0];
            REG_READ_INTERVAL:   cfg_in.read_interval_ms   = csr_write_data;
            REG_DEBOUNCE:        cfg_in.debounce_ms        = csr_write_data;
            REG_LETTER_GAP:      cfg_in.letter_gap_ms      = csr_write_data;
            REG_MSG_TIMEOUT:     cfg_in.message_timeout_ms = csr_write_data;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.light_threshold    <= THRESH_RST;
         cfg_ff.read_interval_ms   <= INTERVAL_RST;
         cfg_ff.debounce_ms        <= DEBOUNCE_RST;
         cfg_ff.letter_gap_ms      <= GAP_RST;
         cfg_ff.message_timeout_ms <= TIMEOUT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lpms_front #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_now_ms   (req_now_ms),
      .req_sample_a (req_sample_a),
      .req_sample_b (req_sample_b),
      .req_sample_c (req_sample_c),
      .poll_push    (poll_push),
      .poll_data    (poll_wr),
      .poll_full    (poll_full)
   );

   // classified polls between front and back
   lpms_fifo #(
      .WIDTH(POLL_W),
      .DEPTH(4)
   ) u_poll_q (
      .clock     (clock),
      .reset     (reset),
      .push      (poll_push),
      .push_data (poll_wr),
      .full      (poll_full),
      .pop       (poll_pop),
      .pop_data  (poll_rd_bits),
      .empty     (poll_empty)
   );

   assign poll_rd = poll_type'(poll_rd_bits);

   lpms_back #(
      .MAX_SYMBOLS(MAX_SYMBOLS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .poll_empty (poll_empty),
      .poll_pop   (poll_pop),
      .poll_data  (poll_rd),
      .ev_push    (ev_push),
      .ev_data    (ev_wr),
      .ev_full    (ev_full)
   );

   // result queue
   lpms_fifo #(
      .WIDTH(EV_W),
      .DEPTH(2)
   ) u_ev_q (
      .clock     (clock),
      .reset     (reset),
      .push      (ev_push),
      .push_data (ev_wr),
      .full      (ev_full),
      .pop       (rsp_pop),
      .pop_data  (ev_rd_bits),
      .empty     (rsp_empty)
   );

   assign ev_rd              = event_type'(ev_rd_bits);
   assign rsp_event_kind     = ev_rd.event_kind;
   assign rsp_message_length = ev_rd.message_length;

endmodule

@@ verif/light_pulse_morse_symbolizer_tb.sv @@
// Self-checking testbench for the Morse symbolizer: directed, back-pressure and random polls.
module light_pulse_morse_symbolizer_tb
   import lpms_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SB   = SAMPLE_BITS_DEF;
   localparam int SW   = SB + 2;
   localparam int MAXS = MAX_SYMBOLS_DEF;
   localparam int SMAX = (1 << SB) - 1;

   logic                  clock;
   logic                  reset;
   logic                  req_push;
   logic                  req_full;
   logic [TIME_W-1:0]     req_now_ms;
   logic [SB-1:0]         req_sample_a;
   logic [SB-1:0]         req_sample_b;
   logic [SB-1:0]         req_sample_c;
   logic                  rsp_empty;
   logic                  rsp_pop;
   logic [KIND_W-1:0]     rsp_event_kind;
   logic [CNT_W-1:0]      rsp_message_length;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CFG_W-1:0]      csr_write_data;

   // predictor copy of the registers and of the symbolizer state
   cfg_type               cur_cfg;
   logic [TIME_W-1:0]     trk_last_poll;
   logic [TIME_W-1:0]     trk_last_change;
   logic                  trk_light;
   logic                  trk_receiving;
   logic [CNT_W-1:0]      trk_count;
   logic                  trk_last_space;
   logic                  trk_double_space;

   event_type             expected_events[$];
   logic [TIME_W-1:0]     sensor_time;
   int unsigned           src_idle_pct;
   int unsigned           sink_idle_pct;
   int unsigned           sink_hold_left;
   int unsigned           error_count;
   int unsigned           results_checked;
   int unsigned           polls_processed;
   int unsigned           settings_used;

   light_pulse_morse_symbolizer i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_now_ms         (req_now_ms),
      .req_sample_a       (req_sample_a),
      .req_sample_b       (req_sample_b),
      .req_sample_c       (req_sample_c),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_event_kind     (rsp_event_kind),
      .rsp_message_length (rsp_message_length),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400_000;
      $display("light_pulse_morse_symbolizer_tb: done, errors");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   // expected symbolizer behavior for one poll; returns 1 when the poll is not skipped
   function automatic bit predict_poll(input logic [TIME_W-1:0] now,
         input logic [SB-1:0] a, input logic [SB-1:0] b, input logic [SB-1:0] c);
      logic [TIME_W-1:0] since;
      logic [SW-1:0]     sum;
      logic [SW-1:0]     avg;
      logic              light;
      event_type         ev;
      since = now - trk_last_poll;
      if (since < TIME_W'(cur_cfg.read_interval_ms)) return 1'b0;
      trk_last_poll = now;
      sum = SW'(a) + SW'(b) + SW'(c);
      avg = sum / SW'(3);
      light = avg > SW'(cur_cfg.light_threshold);
      since = now - trk_last_change;
      // debounced edge
      if (light != trk_light && since > TIME_W'(cur_cfg.debounce_ms)) begin
         if (trk_light) begin
            if (trk_count <= CNT_W'(MAXS)) trk_count = trk_count + CNT_W'(1);
            trk_last_space = 1'b0;
            trk_receiving = 1'b1;
            ev.event_kind = (since >= DASH_MS) ? EV_DASH : EV_DOT;
            ev.message_length = trk_count;
            expected_events.push_back(ev);
         end else if (trk_receiving && since >= TIME_W'(cur_cfg.letter_gap_ms)) begin
            if (trk_last_space) trk_double_space = 1'b1;
            trk_last_space = 1'b1;
            if (trk_count <= CNT_W'(MAXS)) trk_count = trk_count + CNT_W'(1);
            ev.event_kind = EV_SPACE;
            ev.message_length = trk_count;
            expected_events.push_back(ev);
         end
         trk_last_change = now;
         trk_light = light;
      end
      // quiet time ends the message
      since = now - trk_last_change;
      if (trk_receiving && since > TIME_W'(cur_cfg.message_timeout_ms)) begin
         if (trk_count != '0) begin
            ev.event_kind = (trk_double_space || trk_count > CNT_W'(MAXS)) ?
                            EV_END_BAD : EV_END_OK;
            ev.message_length = trk_count;
            expected_events.push_back(ev);
         end
         trk_count = '0;
         trk_last_space = 1'b0;
         trk_double_space = 1'b0;
         trk_receiving = 1'b0;
      end
      return 1'b1;
   endfunction

   // offer one poll item; returns at the falling edge after it is taken
   task automatic send_poll(input logic [TIME_W-1:0] now, input logic [SB-1:0] a,
         input logic [SB-1:0] b, input logic [SB-1:0] c);
      while ($urandom_range(99, 0) < src_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_now_ms <= now;
      req_sample_a <= a;
      req_sample_b <= b;
      req_sample_c <= c;
      @(posedge clock);
      while (req_full) @(posedge clock);
      if (predict_poll(now, a, b, c)) polls_processed++;
      @(negedge clock);
   endtask

   // three samples whose average lands on the requested side of the threshold, clamped to the sample range
   task automatic level_samples(input bit light, output logic [SB-1:0] a,
         output logic [SB-1:0] b, output logic [SB-1:0] c);
      int unsigned thr, v, s, r, lo, hi;
      thr = 32'(cur_cfg.light_threshold);
      if ($urandom_range(3, 0) == 0) v = light ? thr + 1 : thr;
      else if (light) v = $urandom_range(SMAX, thr + 1);
      else v = $urandom_range(thr, 0);
      if (v > SMAX) v = SMAX;
      s = 3 * v + $urandom_range(2, 0);
      if (s > 3 * SMAX) s = 3 * SMAX;
      lo = (s > 2 * SMAX) ? s - 2 * SMAX : 0;
      hi = (s > SMAX) ? SMAX : s;
      a = SB'($urandom_range(hi, lo));
      r = s - 32'(a);
      lo = (r > SMAX) ? r - SMAX : 0;
      hi = (r > SMAX) ? SMAX : r;
      b = SB'($urandom_range(hi, lo));
      c = SB'(r - 32'(b));
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(negedge clock);
   endtask

   // all five registers, written while the block is idle
   task automatic write_config(input cfg_type cfg);
      csr_write(REG_LIGHT_THRESHOLD, CFG_W'(cfg.light_threshold));
      csr_write(REG_READ_INTERVAL, cfg.read_interval_ms);
      csr_write(REG_DEBOUNCE, cfg.debounce_ms);
      csr_write(REG_LETTER_GAP, cfg.letter_gap_ms);
      csr_write(REG_MSG_TIMEOUT, cfg.message_timeout_ms);
      csr_write_enable <= 1'b0;
      @(negedge clock);
      cur_cfg = cfg;
      settings_used++;
   endtask

   function automatic cfg_type make_cfg(input logic [THRESH_W-1:0] th,
         input logic [CFG_W-1:0] iv, input logic [CFG_W-1:0] db,
         input logic [CFG_W-1:0] gp, input logic [CFG_W-1:0] tmo);
      cfg_type cfg;
      cfg.light_threshold = th;
      cfg.read_interval_ms = iv;
      cfg.debounce_ms = db;
      cfg.letter_gap_ms = gp;
      cfg.message_timeout_ms = tmo;
      return cfg;
   endfunction

   // stop offering, let every expected item arrive, then let the pipeline settle
   task automatic wait_idle();
      int unsigned waited;
      waited = 0;
      req_push <= 1'b0;
      while (expected_events.size() != 0 && waited < 20000) begin
         @(negedge clock);
         waited++;
      end
      if (expected_events.size() != 0) begin
         report_mismatch($sformatf("%0d expected items never arrived",
                                   expected_events.size()));
         expected_events.delete();
      end
      repeat (12) @(negedge clock);
   endtask

   // hold one light level for at least dur_ms, with skipped polls and glitches mixed in
   task automatic hold_level(input bit light, input int unsigned dur_ms,
         input int unsigned npolls);
      int unsigned step, roll, ivl;
      logic [SB-1:0] a, b, c;
      ivl = 32'(cur_cfg.read_interval_ms);
      step = dur_ms / npolls + 1;
      if (step < ivl) step = ivl;
      repeat (npolls) begin
         sensor_time += step;
         level_samples(light, a, b, c);
         send_poll(sensor_time, a, b, c);
         roll = $urandom_range(99, 0);
         if (roll < 8 && ivl > 0) begin
            // too soon after the last poll
            send_poll(sensor_time + $urandom_range(ivl - 1, 0),
                      SB'($urandom()), SB'($urandom()), SB'($urandom()));
         end else if (roll < 14) begin
            // short glitch to the other level
            level_samples(!light, a, b, c);
            send_poll(sensor_time + $urandom_range(ivl + 20, ivl), a, b, c);
         end
      end
   endtask

   // pulses and gaps of one message, then quiet past the timeout
   task automatic send_message(input int unsigned nsym, input bit sparse);
      int unsigned on_ms, off_ms, floor_ms, gap_ms, tmo_ms;
      floor_ms = 32'(cur_cfg.debounce_ms) + 1;
      gap_ms = 32'(cur_cfg.letter_gap_ms);
      tmo_ms = 32'(cur_cfg.message_timeout_ms);
      repeat (nsym) begin
         if ($urandom_range(99, 0) < 4)
            on_ms = tmo_ms + 1 + $urandom_range(200, 0);
         else
            on_ms = floor_ms + $urandom_range(250, 0);
         hold_level(1'b1, on_ms, sparse ? 1 : $urandom_range(4, 1));
         if ($urandom_range(99, 0) < 40) begin
            off_ms = (gap_ms > floor_ms) ? gap_ms : floor_ms;
            off_ms += $urandom_range(200, 0);
         end else begin
            off_ms = floor_ms + $urandom_range(150, 0);
         end
         hold_level(1'b0, off_ms, sparse ? 1 : $urandom_range(4, 1));
      end
      hold_level(1'b0, tmo_ms + 1 + $urandom_range(300, 0), $urandom_range(3, 1));
   endtask

   // defaults: skip, threshold boundary, debounce, dot, dash, space, end, time wrap
   task automatic test_basic_symbols();
      sensor_time = 32'hFFFF_FE00;
      send_poll(sensor_time, '0, '0, '0);
      send_poll(sensor_time + 5, SB'(SMAX), SB'(SMAX), SB'(SMAX));
      sensor_time += 60;
      send_poll(sensor_time, SB'(2049), SB'(2049), SB'(2049));
      sensor_time += 20;
      send_poll(sensor_time, SB'(2048), SB'(2048), SB'(2048));
      sensor_time += 80;
      send_poll(sensor_time, SB'(SMAX), '0, '0);
      sensor_time += 600;
      send_poll(sensor_time, SB'(SMAX), SB'(SMAX), SB'(SMAX));
      sensor_time += 200;
      send_poll(sensor_time, '0, SB'(SMAX), SB'(SMAX));
      sensor_time += 50;
      send_poll(sensor_time, '0, '0, SB'(SMAX));
      sensor_time += 100;
      send_poll(sensor_time, SB'(SMAX), SB'(SMAX), SB'(SMAX));
      sensor_time += 100;
      send_poll(sensor_time, '0, '0, '0);
      sensor_time += 3001;
      send_poll(sensor_time, '0, '0, '0);
      wait_idle();
   endtask

   // receiver holds off while every poll after the first makes an item; count saturates, message ends invalid
   task automatic test_backpressure();
      bit lit;
      logic [SB-1:0] a, b, c;
      lit = 1'b0;
      write_config(make_cfg(THRESH_RST, '0, '0, '0, '1));
      src_idle_pct = 0;
      sink_hold_left = 120;
      repeat (56) begin
         lit = !lit;
         sensor_time += 1;
         level_samples(lit, a, b, c);
         send_poll(sensor_time, a, b, c);
      end
      wait_idle();
      sensor_time += 70000;
      level_samples(1'b0, a, b, c);
      send_poll(sensor_time, a, b, c);
      wait_idle();
      src_idle_pct = 18;
   endtask

   // one register setting with random messages until enough polls were processed
   task automatic run_phase(input cfg_type cfg, input int unsigned quota,
         input int unsigned idle_pct);
      int unsigned start, roll;
      wait_idle();
      write_config(cfg);
      src_idle_pct = idle_pct;
      sink_idle_pct = idle_pct;
      start = polls_processed;
      while (polls_processed - start < quota) begin
         roll = $urandom_range(99, 0);
         if (roll < 3) begin
            sensor_time = $urandom();
            send_poll(sensor_time, SB'($urandom()), SB'($urandom()), SB'($urandom()));
         end else if (roll < 10) begin
            send_message($urandom_range(56, 51), 1'b1);
         end else begin
            send_message($urandom_range(8, 1), 1'b0);
         end
      end
   endtask

   task automatic test_random_phases();
      run_phase(make_cfg(THRESH_RST, INTERVAL_RST, DEBOUNCE_RST, GAP_RST, TIMEOUT_RST),
                100, 18);
      run_phase(make_cfg(THRESH_RST, INTERVAL_RST, DEBOUNCE_RST, GAP_RST, TIMEOUT_RST),
                80, 0);
      run_phase(make_cfg('0, 16'd5, 16'd30, 16'd300, 16'd1000), 60, 18);
      run_phase(make_cfg('1, '0, DEBOUNCE_RST, GAP_RST, TIMEOUT_RST), 30, 18);
      run_phase(make_cfg(THRESH_RST, '0, '0, '0, '0), 50, 18);
      run_phase(make_cfg(THRESH_RST, '1, DEBOUNCE_RST, GAP_RST, TIMEOUT_RST), 40, 18);
      run_phase(make_cfg(THRESH_RST, INTERVAL_RST, '1, GAP_RST, TIMEOUT_RST), 40, 18);
      run_phase(make_cfg(THRESH_RST, INTERVAL_RST, DEBOUNCE_RST, '1, '1), 40, 18);
      run_phase(make_cfg(12'd1, '0, '0, '0, '1), 50, 18);
      repeat (3) begin
         run_phase(make_cfg(THRESH_W'($urandom_range(SMAX, 0)),
                            CFG_W'($urandom_range(40, 0)),
                            CFG_W'($urandom_range(120, 0)),
                            CFG_W'($urandom_range(900, 100)),
                            CFG_W'($urandom_range(4000, 200))), 70, 18);
      end
      wait_idle();
   endtask

   // receiver: random pops, or a counted hold-off
   always @(negedge clock) begin
      if (sink_hold_left > 0) begin
         sink_hold_left <= sink_hold_left - 1;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(99, 0) >= sink_idle_pct);
      end
   end

   // compare each popped item with the oldest expectation
   always @(posedge clock) begin : check_events
      event_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_events.size() == 0) begin
            report_mismatch($sformatf("unexpected item kind %0d length %0d",
                                      rsp_event_kind, rsp_message_length));
         end else begin
            want = expected_events.pop_front();
            if (rsp_event_kind !== want.event_kind)
               report_mismatch($sformatf("event_kind %0d, expected %0d",
                                         rsp_event_kind, want.event_kind));
            if (rsp_message_length !== want.message_length)
               report_mismatch($sformatf("message_length %0d, expected %0d",
                                         rsp_message_length, want.message_length));
            results_checked++;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_push = 1'b0;
      req_now_ms = '0;
      req_sample_a = '0;
      req_sample_b = '0;
      req_sample_c = '0;
      rsp_pop = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      cur_cfg = make_cfg(THRESH_RST, INTERVAL_RST, DEBOUNCE_RST, GAP_RST, TIMEOUT_RST);
      trk_last_poll = '0;
      trk_last_change = '0;
      trk_light = 1'b0;
      trk_receiving = 1'b0;
      trk_count = '0;
      trk_last_space = 1'b0;
      trk_double_space = 1'b0;
      sensor_time = '0;
      src_idle_pct = 18;
      sink_idle_pct = 18;
      sink_hold_left = 0;
      error_count = 0;
      results_checked = 0;
      polls_processed = 0;
      settings_used = 1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_basic_symbols();
      test_backpressure();
      test_random_phases();

      $display("summary: %0d polls processed under %0d register settings,",
               polls_processed, settings_used);
      $display("summary: %0d symbol and message-end items checked, %0d mismatches",
               results_checked, error_count);
      if (error_count == 0) begin
         $display("light_pulse_morse_symbolizer_tb: done, clean");
      end else begin
         $display("light_pulse_morse_symbolizer_tb: done, errors");
      end
      $finish;
   end

endmodule
